>>> rtl/terminal_input_line_discipline_unit_defines.svh
// Assertion macros for the terminal input line discipline unit.
// Both macros sample on the rising edge of clk; the first is disabled during reset.
`ifndef TERMINAL_INPUT_LINE_DISCIPLINE_UNIT_DEFINES_SVH
`define TERMINAL_INPUT_LINE_DISCIPLINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TILDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define TILDU_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TILDU_ASSERT(lbl, prop, msg)

`define TILDU_ASSERT_RST(lbl, prop, msg)

`endif

`endif

>>> rtl/tildu_pkg.sv
// Shared types and constants for the terminal input line discipline unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tildu_pkg;

	localparam int unsigned DEF_BUFFER_DEPTH = 128;
	localparam int unsigned COUNT_W          = 9;
	localparam int unsigned CFG_IDX_W        = 3;
	localparam int unsigned CFG_DATA_W       = 1;

	// Command codes.
	localparam logic [1:0] CMD_KEY   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CR_TO_NL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NL_TO_CR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO        = 3'd5;

	// Character codes.
	localparam logic [7:0] KEY_NUL     = 8'h00;
	localparam logic [7:0] KEY_DEL     = 8'h7F;
	localparam logic [7:0] KEY_BS      = 8'h08;
	localparam logic [7:0] KEY_CR      = 8'h0D;
	localparam logic [7:0] KEY_NL      = 8'h0A;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_GAP    = 8'h20;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] key_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]         read_byte;
		logic               read_valid;
		logic               echo_valid;
		logic [7:0]         echo_byte;
		logic               erase_valid;
		logic               line_ready;
		logic               overflow;
		logic [COUNT_W-1:0] input_count;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic fetch;
		logic exec;
	} ctrl_cmd_t;

	function automatic logic is_delim(input logic [7:0] c);
		return (c == KEY_NL) || (c == KEY_CR);
	endfunction

endpackage

`default_nettype wire

>>> rtl/tildu_ctrl.sv
// Controller of the line discipline: sequences store read, update and result hand-off.
// Depends on tildu_pkg and the assertion macro header.
`default_nettype none
`include "terminal_input_line_discipline_unit_defines.svh"

module tildu_ctrl import tildu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_stall,
	output      logic      out_valid,
	input  wire logic      out_stall,
	output      ctrl_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	// The result register can take a new result when empty or being drained now.
	assign out_free  = !out_valid_q || !out_stall;
	assign cmd.fetch = accept;
	assign cmd.exec  = (state_q == ST_EXEC) && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TILDU_ASSERT_RST(a_reset_idle, !arst_n |-> (state_q == ST_IDLE && !out_valid_q), "controller not idle in reset")
	`TILDU_ASSERT(a_accept_to_exec, (in_valid && !in_stall) |=> (state_q == ST_EXEC), "accepted transaction did not start")
	`TILDU_ASSERT(a_exec_loads_out, cmd.exec |=> (out_valid && state_q == ST_IDLE), "result not presented after update")
	`TILDU_ASSERT(a_no_overwrite, (out_valid_q && out_stall) |-> !cmd.exec, "pending result overwritten")

endmodule

`default_nettype wire

>>> rtl/tildu_dp.sv
// Datapath of the line discipline: configuration, both ring buffers and the result register.
// Depends on tildu_pkg and the assertion macro header.
`default_nettype none
`include "terminal_input_line_discipline_unit_defines.svh"

module tildu_dp import tildu_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_t                   in_data,
	input  wire ctrl_cmd_t             cmd,
	output      out_t                  out_data
);

	localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
	localparam int unsigned CW    = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned SUM_W = (CW + 1 > COUNT_W) ? CW + 1 : COUNT_W;
	localparam logic [AW-1:0] LAST_PTR = AW'(BUFFER_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST_PTR : p - AW'(1);
	endfunction

	// Configuration.
	logic canon_q, ign_cr_q, cr_nl_q, nl_cr_q, lower_q, echo_q;

	// Ring buffers.
	logic [7:0]    line_mem [BUFFER_DEPTH];
	logic [7:0]    raw_mem  [BUFFER_DEPTH];
	logic [AW-1:0] line_wr_q, line_rd_q, raw_wr_q, raw_rd_q;
	logic [CW-1:0] line_cnt_q, line_dlm_q, raw_cnt_q, raw_dlm_q;
	logic [AW-1:0] line_wr_d, line_rd_d, raw_wr_d, raw_rd_d;
	logic [CW-1:0] line_cnt_d, line_dlm_d, raw_cnt_d, raw_dlm_d;
	logic [AW-1:0] line_raddr;

	// Item and store data captured at acceptance.
	in_t        item_q;
	logic [7:0] line_rdata_q;
	logic [7:0] raw_rdata_q;

	out_t       out_q;
	out_t       res;
	logic [7:0] key_c;
	logic       drop;
	logic       line_we, raw_we;
	logic       line_empty, line_full, raw_empty, raw_full;
	logic [SUM_W-1:0] count_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canon_q  <= 1'b1;
			ign_cr_q <= 1'b0;
			cr_nl_q  <= 1'b1;
			nl_cr_q  <= 1'b0;
			lower_q  <= 1'b0;
			echo_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CANONICAL:  canon_q  <= cfg_data[0];
				CFG_IGNORE_CR:  ign_cr_q <= cfg_data[0];
				CFG_CR_TO_NL:   cr_nl_q  <= cfg_data[0];
				CFG_NL_TO_CR:   nl_cr_q  <= cfg_data[0];
				CFG_LOWER_CASE: lower_q  <= cfg_data[0];
				CFG_ECHO:       echo_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A key needs the last byte of the line for a delete; other commands pop at the read pointer.
	assign line_raddr = (in_data.cmd == CMD_KEY) ? ptr_dec(line_wr_q) : line_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			item_q       <= in_data;
			line_rdata_q <= line_mem[line_raddr];
			raw_rdata_q  <= raw_mem[raw_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && line_we) line_mem[line_wr_q] <= key_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && raw_we) raw_mem[raw_wr_q] <= item_q.key_byte;
	end

	always_comb begin
		line_empty = (line_cnt_q == '0);
		line_full  = (line_cnt_q == FULL_CNT);
		raw_empty  = (raw_cnt_q == '0);
		raw_full   = (raw_cnt_q == FULL_CNT);

		// Canonical translation of the key.
		key_c = item_q.key_byte;
		drop  = 1'b0;
		if (key_c == KEY_CR) begin
			if (ign_cr_q) drop = 1'b1;
			else if (cr_nl_q) key_c = KEY_NL;
		end else if (key_c == KEY_NL) begin
			if (nl_cr_q) key_c = KEY_CR;
		end
		if (lower_q && key_c >= CHAR_UPPER_A && key_c <= CHAR_UPPER_Z) key_c = key_c + CASE_GAP;

		line_wr_d  = line_wr_q;
		line_rd_d  = line_rd_q;
		line_cnt_d = line_cnt_q;
		line_dlm_d = line_dlm_q;
		raw_wr_d   = raw_wr_q;
		raw_rd_d   = raw_rd_q;
		raw_cnt_d  = raw_cnt_q;
		raw_dlm_d  = raw_dlm_q;
		line_we    = 1'b0;
		raw_we     = 1'b0;
		res        = '0;

		case (item_q.cmd)
			CMD_KEY: begin
				if (item_q.key_byte != KEY_NUL) begin
					if (canon_q) begin
						if (!drop) begin
							if (key_c == KEY_DEL || key_c == KEY_BS) begin
								// A delimiter already in the line cannot be deleted.
								if (!line_empty && !is_delim(line_rdata_q)) begin
									line_wr_d       = ptr_dec(line_wr_q);
									line_cnt_d      = line_cnt_q - ONE_CNT;
									res.erase_valid = 1'b1;
								end
							end else begin
								if (line_full) begin
									res.overflow = 1'b1;
								end else begin
									line_we    = 1'b1;
									line_wr_d  = ptr_inc(line_wr_q);
									line_cnt_d = line_cnt_q + ONE_CNT;
									if (is_delim(key_c)) line_dlm_d = line_dlm_q + ONE_CNT;
								end
								res.line_ready = (line_dlm_d != '0);
							end
							if (echo_q) begin
								res.echo_valid = 1'b1;
								res.echo_byte  = key_c;
							end
						end
					end else begin
						if (raw_full) begin
							res.overflow = 1'b1;
						end else begin
							raw_we    = 1'b1;
							raw_wr_d  = ptr_inc(raw_wr_q);
							raw_cnt_d = raw_cnt_q + ONE_CNT;
							if (is_delim(item_q.key_byte)) raw_dlm_d = raw_dlm_q + ONE_CNT;
						end
						res.line_ready = 1'b1;
					end
				end
			end
			CMD_READ: begin
				if (!raw_empty) begin
					res.read_byte  = raw_rdata_q;
					res.read_valid = 1'b1;
					raw_rd_d       = ptr_inc(raw_rd_q);
					raw_cnt_d      = raw_cnt_q - ONE_CNT;
					if (is_delim(raw_rdata_q) && raw_dlm_q != '0) raw_dlm_d = raw_dlm_q - ONE_CNT;
				end else if (canon_q && !line_empty) begin
					res.read_byte  = line_rdata_q;
					res.read_valid = 1'b1;
					line_rd_d      = ptr_inc(line_rd_q);
					line_cnt_d     = line_cnt_q - ONE_CNT;
					if (is_delim(line_rdata_q) && line_dlm_q != '0) line_dlm_d = line_dlm_q - ONE_CNT;
				end
			end
			CMD_CLEAR: begin
				line_wr_d  = '0;
				line_rd_d  = '0;
				line_cnt_d = '0;
				line_dlm_d = '0;
				raw_wr_d   = '0;
				raw_rd_d   = '0;
				raw_cnt_d  = '0;
				raw_dlm_d  = '0;
			end
			default: ;
		endcase

		count_sum = SUM_W'(raw_cnt_d) + (canon_q ? SUM_W'(line_cnt_d) : '0);
		res.input_count = count_sum[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_wr_q  <= '0;
			line_rd_q  <= '0;
			line_cnt_q <= '0;
			line_dlm_q <= '0;
			raw_wr_q   <= '0;
			raw_rd_q   <= '0;
			raw_cnt_q  <= '0;
			raw_dlm_q  <= '0;
		end else if (cmd.exec) begin
			line_wr_q  <= line_wr_d;
			line_rd_q  <= line_rd_d;
			line_cnt_q <= line_cnt_d;
			line_dlm_q <= line_dlm_d;
			raw_wr_q   <= raw_wr_d;
			raw_rd_q   <= raw_rd_d;
			raw_cnt_q  <= raw_cnt_d;
			raw_dlm_q  <= raw_dlm_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) out_q <= res;
	end

	assign out_data = out_q;

	`TILDU_ASSERT(a_line_dlm_bound, line_dlm_q <= line_cnt_q, "line delimiter count exceeds occupancy")
	`TILDU_ASSERT(a_raw_dlm_bound, raw_dlm_q <= raw_cnt_q, "raw delimiter count exceeds occupancy")
	`TILDU_ASSERT(a_clear_empties, (cmd.exec && item_q.cmd == CMD_CLEAR) |=> (line_cnt_q == '0 && raw_cnt_q == '0), "clear left bytes behind")

endmodule

`default_nettype wire

>>> rtl/terminal_input_line_discipline_unit.sv
// Top level of the terminal input line discipline: controller plus datapath, uses tildu_pkg.
// An accepted transaction and its store read are registered, then the update runs in the
// execute state and loads the result register; no new transaction is taken until the
// update is done, and a stalled result holds the update until it is taken.
// Reset clears pointers, counts and handshake state and loads configuration defaults;
// store contents are not cleared and no clearing pass runs.
`default_nettype none

module terminal_input_line_discipline_unit import tildu_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire in_t                   in_data,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      out_t                  out_data
);

	ctrl_cmd_t cmd;

	tildu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tildu_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
